[rtl/pwmps_pkg.sv]
// Shared types, codes and constants of the PWM prescale/period search unit.
package pwmps_pkg;

  localparam longint unsigned NS_PER_SEC = 64'd1000000000;
  localparam logic [31:0] RATE_RESET = 32'd60000000;

  localparam int unsigned MAX_PRESCALE_DEF = 16383;
  localparam longint unsigned MAX_COUNT_DEF = 64'd65535;
  localparam int unsigned CHANNELS_DEF = 3;

  // rate (32 b) times a time in ns (31 b)
  localparam int unsigned DVD_W = 63;
  // quotient of a 63-bit dividend by a divisor of at least 1e9 stays below 2^34
  localparam int unsigned QUOT_W = 34;
  localparam int unsigned HI_W = DVD_W - QUOT_W;

  localparam longint unsigned DIV_MAX_DEF = NS_PER_SEC * (MAX_PRESCALE_DEF + 1);
  localparam int unsigned DIV_W_DEF = $clog2(DIV_MAX_DEF + 1);

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_SHORT       = 2'd1,
    STS_OVERFLOW    = 2'd2,
    STS_BAD_CHANNEL = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  channel;
    logic [30:0] duty_ns;
    logic [30:0] period_time;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [13:0] prescale;
    logic [15:0] period_count;
    logic [15:0] duty_count;
    logic        load_pair;
    logic        load_upper_half;
  } out_t;

endpackage

[rtl/pwm_prescale_period_search_unit.sv]
// Top level of the PWM prescale/period search unit: sequencer, shared multiplier, result register.
//
//  Channel   Handshake                  Payload            Direction
//  in        in_valid_i / in_stall_o    in_data_i  (in_t)  request item
//  out       out_valid_o / out_stall_i  out_data_o (out_t) result item
//  cfg       cfg_valid_i / cfg_ready_o  cfg_data_i [31:0]  clock rate write
//
// One item at a time. Each item runs T prescale trials, T from 1 to MAX_PRESCALE+1; the next item
// is taken once the sequencer has returned to idle.
// Each trial is two 34-step runs of the shared divider, period then duty, followed by the evaluation state.
// The two products rate*ns come from one multiplier, period in S_MUL_P and duty in S_MUL_D.
// Reset sets the clock rate to 60 MHz and clears the sequencer; no clearing pass.
// in_stall_o is high from acceptance until the result is moved to the output register;
// a stalled result stays in the output register while the next item is taken.
module pwm_prescale_period_search_unit #(
  parameter int unsigned      MAX_PRESCALE = pwmps_pkg::MAX_PRESCALE_DEF,
  parameter longint unsigned  MAX_COUNT    = pwmps_pkg::MAX_COUNT_DEF,
  parameter int unsigned      CHANNELS     = pwmps_pkg::CHANNELS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pwmps_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pwmps_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [31:0]     cfg_data_i
);
  import pwmps_pkg::*;

  localparam longint unsigned DIV_MAX = NS_PER_SEC * (MAX_PRESCALE + 1);
  localparam int unsigned     DIV_W   = $clog2(DIV_MAX + 1);
  localparam int unsigned     PRE_W   = $clog2(MAX_PRESCALE + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_D,
    S_START_P,
    S_DIV_P,
    S_START_D,
    S_DIV_D,
    S_EVAL,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [31:0]        rate_q;
  logic [1:0]         ch_q;
  logic [30:0]        duty_q;
  logic [30:0]        period_q;
  logic [DVD_W-1:0]   pnum_q;
  logic [DVD_W-1:0]   dnum_q;
  logic [DIV_W-1:0]   divisor_q;
  logic [PRE_W-1:0]   pre_q;
  logic [QUOT_W-1:0]  pv_q;
  logic [QUOT_W-1:0]  dc_q;
  out_t               res_q;
  out_t               res_d;
  out_t               out_q;
  logic               out_valid_q;

  logic [30:0]        mul_b;
  logic [DVD_W-1:0]   prod;
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic               div_done;
  logic [QUOT_W-1:0]  div_quot;
  logic               out_free;
  logic               cnt_short;
  logic               cnt_over;
  logic               pre_last;
  logic               ch_bad;

  assign mul_b        = (state_q == S_MUL_P) ? period_q : duty_q;
  assign prod         = DVD_W'(rate_q) * DVD_W'(mul_b);
  assign div_start    = (state_q == S_START_P) || (state_q == S_START_D);
  assign div_dividend = (state_q == S_START_D) ? dnum_q : pnum_q;
  assign out_free     = !out_valid_q || !out_stall_i;

  assign cnt_short = (pv_q == '0) || (dc_q == '0);
  assign cnt_over  = (pv_q > QUOT_W'(MAX_COUNT)) || (dc_q > QUOT_W'(MAX_COUNT));
  assign pre_last  = (pre_q == PRE_W'(MAX_PRESCALE));
  assign ch_bad    = ({2'b00, ch_q} >= 4'(CHANNELS));

  // short beats overflow, and both beat a bad channel
  always_comb begin
    res_d = '0;
    priority if (cnt_short) begin
      res_d.status = STS_SHORT;
    end else if (cnt_over) begin
      res_d.status = STS_OVERFLOW;
    end else if (ch_bad) begin
      res_d.status = STS_BAD_CHANNEL;
    end else begin
      res_d.status          = STS_OK;
      res_d.prescale        = 14'(pre_q);
      res_d.period_count    = pv_q[15:0];
      res_d.duty_count      = dc_q[15:0];
      res_d.load_pair       = ch_q[1];
      res_d.load_upper_half = ch_q[0];
    end
  end

  pwmps_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= RATE_RESET;
      ch_q        <= '0;
      duty_q      <= '0;
      period_q    <= '0;
      pnum_q      <= '0;
      dnum_q      <= '0;
      divisor_q   <= '0;
      pre_q       <= '0;
      pv_q        <= '0;
      dc_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rate_q <= cfg_data_i;
      end
      if (out_free) begin
        out_valid_q <= (state_q == S_DONE);
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ch_q     <= in_data_i.channel;
            duty_q   <= in_data_i.duty_ns;
            period_q <= in_data_i.period_time;
            state_q  <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          pnum_q    <= prod;
          divisor_q <= DIV_W'(NS_PER_SEC);
          pre_q     <= '0;
          state_q   <= S_MUL_D;
        end
        S_MUL_D: begin
          dnum_q  <= prod;
          state_q <= S_START_P;
        end
        S_START_P: state_q <= S_DIV_P;
        S_DIV_P: begin
          if (div_done) begin
            pv_q    <= div_quot;
            state_q <= S_START_D;
          end
        end
        S_START_D: state_q <= S_DIV_D;
        S_DIV_D: begin
          if (div_done) begin
            dc_q    <= div_quot;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (cnt_over && !cnt_short && !pre_last) begin
            pre_q     <= pre_q + 1'b1;
            divisor_q <= divisor_q + DIV_W'(NS_PER_SEC);
            state_q   <= S_START_P;
          end else begin
            res_q   <= res_d;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  a_error_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != STS_OK) |->
      (out_data_o.prescale == '0 && out_data_o.period_count == '0 &&
       out_data_o.duty_count == '0 && !out_data_o.load_pair &&
       !out_data_o.load_upper_half))
    else $error("error result carries nonzero payload");

  a_divisor_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_EVAL && state_q == S_START_P) |->
      (divisor_q == $past(divisor_q) + DIV_W'(NS_PER_SEC) && pre_q == $past(pre_q) + 1'b1))
    else $error("divisor and prescale out of step");

endmodule

[rtl/pwmps_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module pwmps_div #(
  parameter int unsigned DIV_W = pwmps_pkg::DIV_W_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pwmps_pkg::DVD_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]            divisor_i,
  output logic                        done_o,
  output logic [pwmps_pkg::QUOT_W-1:0] quot_o
);
  import pwmps_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_W:0]     rem_q;
  logic [DIV_W:0]     rem_d;
  logic [DIV_W:0]     trial;
  logic [QUOT_W-1:0]  dvd_q;
  logic [QUOT_W-1:0]  quot_q;
  logic               ge;

  // divisor_i must hold while busy
  always_comb begin
    trial = {rem_q[DIV_W-1:0], dvd_q[QUOT_W-1]};
    ge    = trial >= {1'b0, divisor_i};
    rem_d = ge ? trial - {1'b0, divisor_i} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // upper dividend bits are below 2^29 <= 1e9, so they start as the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= (DIV_W + 1)'(dividend_i[DVD_W-1 -: HI_W]);
      dvd_q  <= dividend_i[QUOT_W-1:0];
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < {1'b0, divisor_i})
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule
